/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the slot cache RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/slc_pkg.sv */
// Package for the segmented LRU slot cache: types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slc_pkg;
    localparam int SlotsDef = 16;
    localparam int NumExpertsDef = 256;
    localparam int InflightBitsDef = 16;

    typedef enum logic [2:0] {
        CMD_REQUEST = 3'd0, CMD_MARK_READY = 3'd1, CMD_ACQUIRE = 3'd2,
        CMD_RELEASE = 3'd3, CMD_DECAY = 3'd4, CMD_CLEAR = 3'd5,
        CMD_BAD6 = 3'd6, CMD_BAD7 = 3'd7
    } cmd_t;

    localparam logic [2:0] R_HIT = 3'd0;
    localparam logic [2:0] R_LOADING = 3'd1;
    localparam logic [2:0] R_RESERVED = 3'd2;
    localparam logic [2:0] R_NOADMIT = 3'd3;
    localparam logic [2:0] R_BLOCKED = 3'd4;
    localparam logic [2:0] R_ACCEPT = 3'd5;
    localparam logic [2:0] R_REJECT = 3'd6;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LOADING = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    localparam logic [1:0] REG_SLOTS = 2'd0;
    localparam logic [1:0] REG_PROT = 2'd1;
    localparam logic [1:0] REG_STM = 2'd2;
    localparam logic [1:0] REG_ADP = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  expert_id;
        logic        may_reserve;
        logic        is_prefill;
        logic [3:0]  handle_slot;
        logic [31:0] handle_generation;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  result_slot;
        logic [31:0] result_generation;
        logic        evicted_valid;
        logic [7:0]  evicted_expert;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_HCHECK, S_SCAN1, S_DECIDE, S_SCAN2, S_APPLY,
        S_CLEAR, S_DECAY, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic apply;
        logic handle_apply;
        logic clear_step;
        logic decay_step;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       scan_last;
        logic       need_scan2;
        logic       clear_last;
        logic       decay_last;
        logic [2:0] command;
    } ctl_sts_t;
endpackage
`default_nettype wire

/* hw/rtl/slc_ctrl.sv */
// Sequencer for the slot cache: steps scans, clears and decay sweeps.
// Depends on slc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module slc_ctrl
    import slc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ctl_cmd_t      cmd,
    input  wire ctl_sts_t sts
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_HCHECK;
                end
            end
            S_HCHECK:
            begin
                unique case (cmd_t'(sts.command))
                    CMD_REQUEST:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = S_SCAN1;
                    end
                    CMD_MARK_READY, CMD_ACQUIRE, CMD_RELEASE:
                    begin
                        cmd.handle_apply = 1'b1;
                        state_next = S_OUT;
                    end
                    CMD_DECAY: state_next = S_DECAY;
                    CMD_CLEAR: state_next = S_CLEAR;
                    default: state_next = S_OUT;
                endcase
            end
            S_SCAN1:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.need_scan2)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN2;
                end
                else
                    state_next = S_APPLY;
            end
            S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                state_next = S_OUT;
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                    state_next = S_OUT;
            end
            S_DECAY:
            begin
                cmd.decay_step = 1'b1;
                if (sts.decay_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid)
    `ASSERT_NXT(a_load_leaves_idle, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

/* hw/rtl/slc_datapath.sv */
// Slot state, history bitmap, scan unit and result register.
// Depends on slc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slc_datapath
    import slc_pkg::*;
#(
    parameter int SLOTS = SlotsDef,
    parameter int NUM_EXPERTS = NumExpertsDef,
    parameter int INFLIGHT_BITS = InflightBitsDef
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_item,
    input  wire ctl_cmd_t cmd,
    output ctl_sts_t      sts,
    output out_item_t     out_item,
    input  wire logic [4:0] slots_in_use,
    input  wire logic [3:0] protected_limit,
    input  wire logic       second_touch_mode,
    input  wire logic       admit_during_prefill
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int HW = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;
    localparam logic [INFLIGHT_BITS-1:0] IF_MAX = '1;
    localparam logic [INFLIGHT_BITS-1:0] IF_ONE = INFLIGHT_BITS'(1);

    logic [7:0]               expert_reg [SLOTS];
    logic [1:0]               status_reg [SLOTS];
    logic                     seg_reg    [SLOTS];
    logic [INFLIGHT_BITS-1:0] infl_reg   [SLOTS];
    logic [31:0]              freq_reg   [SLOTS];
    logic [63:0]              last_reg   [SLOTS];
    logic [31:0]              gen_reg    [SLOTS];
    logic [63:0]              clock_reg;
    logic [NUM_EXPERTS-1:0]   seen_reg;

    in_item_t  item_reg;
    out_item_t res_reg;
    logic [CW-1:0] cap_reg;
    logic [HW-1:0] h_reg;
    logic [CW-1:0] idx_reg;
    logic          pass_reg;      // 0 first scan, 1 demotion scan
    logic          hit_f_reg;
    logic [SW-1:0] hit_reg;
    logic          emp_f_reg;
    logic [SW-1:0] emp_reg;
    logic          vic_f_reg;
    logic [SW-1:0] vic_reg;
    logic [63:0]   vic_old_reg;
    logic [CW-1:0] pcnt_reg;
    logic          dem_f_reg;
    logic [SW-1:0] dem_reg;
    logic [63:0]   dem_old_reg;
    logic          promo_reg;
    logic          seen_bit_reg;
    logic [HW-1:0] clr_reg;
    logic [SW-1:0] dec_reg;

    logic [SW-1:0] si;
    logic [SW-1:0] hs;
    logic          hs_in;
    logic          admit_ok;
    logic [SW-1:0] vsel;
    logic [63:0]   tick_val;

    // expert id modulo NUM_EXPERTS by shift-and-subtract against a constant
    function automatic logic [HW-1:0] hist_index(input logic [7:0] e);
        logic [31:0] r;
        r = {24'd0, e};
        for (int k = 7; k >= 0; k--)
            if (r >= (32'(NUM_EXPERTS) << k))
                r = r - (32'(NUM_EXPERTS) << k);
        return HW'(r);
    endfunction

    assign si = idx_reg[SW-1:0];
    assign hs = SW'(item_reg.handle_slot);
    assign hs_in = ({28'd0, item_reg.handle_slot} < 32'(cap_reg))
        && (32'(item_reg.handle_slot) < SLOTS);

    assign sts.scan_last = (idx_reg + CW'(1) >= cap_reg) || (cap_reg == '0);
    assign sts.clear_last = (clr_reg == HW'(NUM_EXPERTS - 1));
    assign sts.decay_last = (dec_reg == SW'(SLOTS - 1));
    assign sts.command = item_reg.command;
    // promotion of a probation hit needing the protected count
    assign sts.need_scan2 = hit_f_reg && status_reg[hit_reg] == ST_READY
        && !seg_reg[hit_reg] && protected_limit != 4'd0;
    assign out_item = res_reg;

    assign tick_val = (clock_reg == '1) ? clock_reg : clock_reg + 64'd1;
    assign admit_ok = (cap_reg != '0) && item_reg.may_reserve
        && !(item_reg.is_prefill && !admit_during_prefill);
    assign vsel = emp_f_reg ? emp_reg : vic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                expert_reg[i] <= '0;
                status_reg[i] <= ST_EMPTY;
                seg_reg[i] <= 1'b0;
                infl_reg[i] <= '0;
                freq_reg[i] <= '0;
                last_reg[i] <= '0;
                gen_reg[i] <= '0;
            end
            clock_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            if (cmd.handle_apply)
            begin
                unique case (cmd_t'(item_reg.command))
                    CMD_MARK_READY:
                        if (hs_in && gen_reg[hs] == item_reg.handle_generation
                            && status_reg[hs] == ST_LOADING)
                            status_reg[hs] <= ST_READY;
                    CMD_ACQUIRE:
                        if (hs_in && gen_reg[hs] == item_reg.handle_generation
                            && status_reg[hs] == ST_READY)
                        begin
                            clock_reg <= tick_val;
                            last_reg[hs] <= tick_val;
                            if (infl_reg[hs] != IF_MAX)
                                infl_reg[hs] <= infl_reg[hs] + IF_ONE;
                        end
                    CMD_RELEASE:
                        if (hs_in && gen_reg[hs] == item_reg.handle_generation
                            && status_reg[hs] == ST_READY && infl_reg[hs] != '0)
                            infl_reg[hs] <= infl_reg[hs] - IF_ONE;
                    default: ;
                endcase
            end
            if (cmd.clear_step)
                seen_reg[clr_reg] <= 1'b0;
            if (cmd.decay_step)
                freq_reg[dec_reg] <= (freq_reg[dec_reg] >> 1)
                    + {31'd0, freq_reg[dec_reg][0]};
            if (cmd.decide)
                clock_reg <= tick_val;
            if (cmd.apply)
            begin
                if (hit_f_reg)
                begin
                    last_reg[hit_reg] <= clock_reg;
                    if (status_reg[hit_reg] == ST_READY)
                    begin
                        if (freq_reg[hit_reg] != '1)
                            freq_reg[hit_reg] <= freq_reg[hit_reg] + 32'd1;
                        if (infl_reg[hit_reg] != IF_MAX)
                            infl_reg[hit_reg] <= infl_reg[hit_reg] + IF_ONE;
                        if (promo_reg)
                        begin
                            if (pcnt_reg >= CW'(protected_limit) && dem_f_reg)
                                seg_reg[dem_reg] <= 1'b0;
                            seg_reg[hit_reg] <= 1'b1;
                        end
                    end
                end
                else if (admit_ok && (!second_touch_mode || seen_bit_reg))
                begin
                    if (second_touch_mode)
                        seen_reg[h_reg] <= 1'b0;
                    if (emp_f_reg || vic_f_reg)
                    begin
                        gen_reg[vsel] <= gen_reg[vsel] + 32'd1;
                        expert_reg[vsel] <= item_reg.expert_id;
                        status_reg[vsel] <= ST_LOADING;
                        seg_reg[vsel] <= 1'b0;
                        infl_reg[vsel] <= '0;
                        freq_reg[vsel] <= 32'd1;
                        last_reg[vsel] <= clock_reg;
                    end
                end
                else if (admit_ok)
                    seen_reg[h_reg] <= 1'b1;
            end
        end
    end

    // control and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            pass_reg <= 1'b0;
            clr_reg <= '0;
            dec_reg <= '0;
            hit_f_reg <= 1'b0;
            hit_reg <= '0;
            emp_f_reg <= 1'b0;
            emp_reg <= '0;
            vic_f_reg <= 1'b0;
            vic_reg <= '0;
            vic_old_reg <= '0;
            dem_f_reg <= 1'b0;
            dem_reg <= '0;
            dem_old_reg <= '0;
            promo_reg <= 1'b0;
            seen_bit_reg <= 1'b0;
            pcnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                clr_reg <= '0;
                dec_reg <= '0;
                promo_reg <= 1'b0;
            end
            if (cmd.clear_step)
                clr_reg <= clr_reg + HW'(1);
            if (cmd.decay_step)
                dec_reg <= dec_reg + SW'(1);
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
                pass_reg <= cmd.decide;
                if (!cmd.decide)
                begin
                    hit_f_reg <= 1'b0;
                    emp_f_reg <= 1'b0;
                    vic_f_reg <= 1'b0;
                end
                dem_f_reg <= 1'b0;
                pcnt_reg <= '0;
            end
            if (cmd.decide)
            begin
                promo_reg <= sts.need_scan2;
                seen_bit_reg <= seen_reg[h_reg];
            end
            if (cmd.scan_step && cap_reg != '0)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (!pass_reg)
                begin
                    if (!hit_f_reg && status_reg[si] != ST_EMPTY
                        && expert_reg[si] == item_reg.expert_id)
                    begin
                        hit_f_reg <= 1'b1;
                        hit_reg <= si;
                    end
                    if (!emp_f_reg && status_reg[si] == ST_EMPTY)
                    begin
                        emp_f_reg <= 1'b1;
                        emp_reg <= si;
                    end
                    if (status_reg[si] == ST_READY && !seg_reg[si] && infl_reg[si] == '0
                        && (!vic_f_reg || last_reg[si] < vic_old_reg))
                    begin
                        vic_f_reg <= 1'b1;
                        vic_reg <= si;
                        vic_old_reg <= last_reg[si];
                    end
                end
                else
                begin
                    if (status_reg[si] != ST_EMPTY && seg_reg[si])
                        pcnt_reg <= pcnt_reg + CW'(1);
                    if (si != hit_reg && status_reg[si] == ST_READY && seg_reg[si]
                        && (!dem_f_reg || last_reg[si] < dem_old_reg))
                    begin
                        dem_f_reg <= 1'b1;
                        dem_reg <= si;
                        dem_old_reg <= last_reg[si];
                    end
                end
            end
        end
    end

    // payload and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            h_reg <= hist_index(in_item.expert_id);
            cap_reg <= (32'(slots_in_use) > SLOTS) ? CW'(SLOTS) : CW'(slots_in_use);
            res_reg <= '{status: R_REJECT, default: '0};
        end
        if (cmd.handle_apply)
            res_reg.status <= (hs_in && gen_reg[hs] == item_reg.handle_generation
                && ((item_reg.command == CMD_MARK_READY && status_reg[hs] == ST_LOADING)
                    || (item_reg.command == CMD_ACQUIRE && status_reg[hs] == ST_READY)
                    || (item_reg.command == CMD_RELEASE && status_reg[hs] == ST_READY
                        && infl_reg[hs] != '0))) ? R_ACCEPT : R_REJECT;
        if (cmd.clear_step || cmd.decay_step)
            res_reg.status <= R_ACCEPT;
        if (cmd.apply)
        begin
            if (hit_f_reg)
            begin
                res_reg.result_slot <= 4'(hit_reg);
                res_reg.result_generation <= gen_reg[hit_reg];
                res_reg.status <= (status_reg[hit_reg] == ST_LOADING) ? R_LOADING : R_HIT;
            end
            else if (!admit_ok || (second_touch_mode && !seen_bit_reg))
                res_reg.status <= R_NOADMIT;
            else if (!(emp_f_reg || vic_f_reg))
                res_reg.status <= R_BLOCKED;
            else
            begin
                res_reg.status <= R_RESERVED;
                res_reg.result_slot <= 4'(vsel);
                res_reg.result_generation <= gen_reg[vsel] + 32'd1;
                res_reg.evicted_valid <= !emp_f_reg;
                res_reg.evicted_expert <= emp_f_reg ? 8'd0 : expert_reg[vsel];
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/slc_regs.sv */
// APB configuration registers of the slot cache.
// Depends on slc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slc_regs
    import slc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [4:0]       slots_in_use,
    output logic [3:0]       protected_limit,
    output logic             second_touch_mode,
    output logic             admit_during_prefill
);
    logic [4:0] siu_reg;
    logic [3:0] pl_reg;
    logic       stm_reg, adp_reg;
    logic [1:0] ridx;

    assign ridx = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg <= 5'd16;
            pl_reg <= 4'd12;
            stm_reg <= 1'b0;
            adp_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (ridx)
                REG_SLOTS: siu_reg <= pwdata[4:0];
                REG_PROT:  pl_reg <= pwdata[3:0];
                REG_STM:   stm_reg <= pwdata[0];
                REG_ADP:   adp_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_SLOTS: prdata = {27'd0, siu_reg};
            REG_PROT:  prdata = {28'd0, pl_reg};
            REG_STM:   prdata = {31'd0, stm_reg};
            REG_ADP:   prdata = {31'd0, adp_reg};
            default:   prdata = '0;
        endcase
    end

    assign slots_in_use = siu_reg;
    assign protected_limit = pl_reg;
    assign second_touch_mode = stm_reg;
    assign admit_during_prefill = adp_reg;
endmodule
`default_nettype wire

/* hw/rtl/segmented_lru_slot_cache.sv */
// Segmented LRU slot cache: one transaction at a time, n = min(slots_in_use, SLOTS).
// Handle commands and unknown codes go straight to the result; a request scans the n
// active slots, twice when a probation hit is promoted; decay sweeps all SLOTS slots
// and clear history all NUM_EXPERTS bits; next input waits for the result handshake.
// Reset is asynchronous, active low, clears all slot state and the history at once.
`timescale 1ns / 1ps
`default_nettype none
module segmented_lru_slot_cache
    import slc_pkg::*;
#(
    parameter int SLOTS = SlotsDef,
    parameter int NUM_EXPERTS = NumExpertsDef,
    parameter int INFLIGHT_BITS = InflightBitsDef
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    ctl_cmd_t   cmd;
    ctl_sts_t   sts;
    logic [4:0] siu;
    logic [3:0] pl;
    logic       stm, adp;

    slc_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .slots_in_use(siu), .protected_limit(pl), .second_touch_mode(stm),
        .admit_during_prefill(adp)
    );

    slc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    slc_datapath #(
        .SLOTS(SLOTS), .NUM_EXPERTS(NUM_EXPERTS), .INFLIGHT_BITS(INFLIGHT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .sts(sts),
        .out_item(out_data), .slots_in_use(siu), .protected_limit(pl),
        .second_touch_mode(stm), .admit_during_prefill(adp)
    );
endmodule
`default_nettype wire
